@@ hw/rtl/ufrt_pkg.sv @@
// Shared types and codes for the frame reassembly tracker.
package ufrt_pkg;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] frame_no;
		logic [7:0]  data_type;
		logic [7:0]  subframe_index;
		logic [15:0] packet_index;
		logic [15:0] block_size;
		logic [15:0] packet_bytes;
		logic [2:0]  returned_buffer;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [2:0]  buf_idx;
		logic [31:0] frame_out;
		logic [8:0]  payload_slot;
		logic [9:0]  missing_count;
		logic [31:0] bad_packet_count;
		logic        last;
	} out_item_t;

	localparam logic [1:0] OP_PACKET = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_RETURN = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	localparam logic [2:0] EV_ACCEPT  = 3'd0;
	localparam logic [2:0] EV_REJECT  = 3'd1;
	localparam logic [2:0] EV_DISCARD = 3'd2;
	localparam logic [2:0] EV_DONE    = 3'd3;
	localparam logic [2:0] EV_TIMEOUT = 3'd4;
	localparam logic [2:0] EV_TICK    = 3'd5;
	localparam logic [2:0] EV_RETURN  = 3'd6;

	localparam logic [1:0] REG_PAYLOAD = 2'd0;
	localparam logic [1:0] REG_HEADER  = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	localparam int          DROP_KEEP = 3;
	localparam logic [9:0]  MISS_MAX  = 10'h3ff;
	localparam logic [7:0]  HDR_MASK  = 8'hff;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOK,
		ST_DSCAN,
		ST_DACT,
		ST_SWEEP,
		ST_CHECK,
		ST_RESOLVE,
		ST_TSCAN,
		ST_TEVAL,
		ST_TRIM,
		ST_TDONE,
		ST_RET
	} state_t;

endpackage

@@ hw/rtl/udp_frame_reassembly_tracker_unit.sv @@
// Frame reassembly tracker top level: header checks, buffer pool, drop list, timeouts.
//
// Input channel in_valid/in_stall/in_data carries one item: a packet header,
// a millisecond tick or a buffer return. Output channel out_valid/out_stall/
// out_data gives the results; the final result of an item has last set.
// Configuration: cfg_wr_en with cfg_index and cfg_data, to be written while idle; the block does not enforce this.
// One item is worked on at a time; in_stall is high until its last result
// sits in the output register. A packet of a known frame goes through lookup,
// seen-bit read and resolve. A packet opening a new frame adds a clearing
// sweep of the seen bits, one slot a cycle, after a scan of the drop list
// when a full drop list evicts its smallest frame. A tick scans the buffers
// one a cycle, scanning again after each timed-out frame that it reports and
// once more to find none, then trims the drop list, scanning it once per
// removed entry, and gives its last result. A return gives its result once
// the output register is free. The output register lets a new item in while
// a result waits; a stalled receiver holds the work at the emitting step.
// Reset empties the drop list, unmaps all buffers and fills the free pool
// with every id in order.
module udp_frame_reassembly_tracker_unit
	import ufrt_pkg::*;
#(
	parameter int NUM_TYPES     = 2,
	parameter int NUM_SUBS      = 2,
	parameter int NUM_PACKETS   = 128,
	parameter int NUM_BUFFERS   = 8,
	parameter int DROP_SLOTS    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int TOTAL = NUM_TYPES * NUM_SUBS * NUM_PACKETS;
	localparam int IDW   = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam int BUFW  = $clog2(NUM_BUFFERS + 1);
	localparam int CNTW  = $clog2(NUM_BUFFERS + 1);
	localparam int CW    = $clog2(TOTAL + 1);
	localparam int SLW   = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int DSW   = $clog2(DROP_SLOTS);
	localparam int DCW   = $clog2(DROP_SLOTS + 1);
	localparam int DEPTH = (NUM_BUFFERS + 1) * TOTAL;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [BUFW-1:0] DUMMY = BUFW'(NUM_BUFFERS);

	state_t state_q, state_d;

	logic [15:0] exp_q;
	logic [7:0]  hdr_q;
	logic [15:0] tmo_q;

	in_item_t    in_q;
	logic        cur_valid_q;
	logic [31:0] cur_frame_q;
	logic [BUFW-1:0] cur_buf_q;

	logic [31:0]   tag_q     [NUM_BUFFERS];
	logic [31:0]   start_q   [NUM_BUFFERS];
	logic          mapped_q  [NUM_BUFFERS];
	logic [CW-1:0] rc_q      [NUM_BUFFERS + 1];
	logic [IDW-1:0] pool_q   [NUM_BUFFERS];
	logic          inpool_q  [NUM_BUFFERS];
	logic [IDW-1:0] head_q;
	logic [CNTW-1:0] cnt_q;

	logic          dvalid_q  [DROP_SLOTS];
	logic [31:0]   dframe_q  [DROP_SLOTS];
	logic [DSW-1:0] didx_q, dbest_q;
	logic          dfound_q, dtrim_q;

	logic [IDW-1:0] tidx_q, tbest_q;
	logic          tfound_q;

	logic [31:0]   tick_q;
	logic [31:0]   bad_q;

	logic [BUFW-1:0] sweep_buf_q;
	logic [SLW-1:0]  sweep_q;

	logic          ok_q;
	logic [AW-1:0] addr_q;
	logic [8:0]    slot_q;

	logic          out_valid_q;
	out_item_t     out_q;

	// lookup and check logic
	logic          in_acc, out_free, new_frame;
	logic          map_hit, drop_hit, free_found;
	logic [IDW-1:0] map_idx;
	logic [DSW-1:0] free_idx;
	logic [IDW-1:0] alloc_id;
	logic          ok_pre;
	logic [31:0]   slot32, addr32, sweep32, id32, buf32;
	logic [16:0]   size_sum;
	logic          t_cond, t_better, d_better;
	logic [DCW-1:0] dcount;
	logic [CNTW:0] tail_sum;
	logic [IDW-1:0] tail_idx;
	logic [IDW-1:0] cur_idx, ret_idx;
	logic          cur_real, ret_ok;
	logic [CW-1:0] rc_next, miss_full;
	logic [31:0]   bad_next;
	logic          seen_bit;
	logic          mem_rd_en, mem_wr_en, mem_wr_data;
	logic [AW-1:0] mem_wr_addr;
	logic          out_load;
	out_item_t     out_next;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign new_frame = !cur_valid_q || (in_q.frame_no != cur_frame_q);
	assign alloc_id  = pool_q[head_q];
	assign cur_idx   = cur_buf_q[IDW-1:0];
	assign cur_real  = (cur_buf_q != DUMMY);
	assign buf32     = cur_real ? 32'(cur_buf_q) : 32'd0;
	assign id32      = 32'(in_q.returned_buffer);
	assign ret_idx   = id32[IDW-1:0];

	always_comb begin
		map_hit    = 1'b0;
		map_idx    = '0;
		drop_hit   = 1'b0;
		free_found = 1'b0;
		free_idx   = '0;
		dcount     = '0;
		for (int b = NUM_BUFFERS - 1; b >= 0; b--) begin
			if (mapped_q[b] && tag_q[b] == in_q.frame_no) begin
				map_hit = 1'b1;
				map_idx = IDW'(b);
			end
		end
		for (int i = DROP_SLOTS - 1; i >= 0; i--) begin
			if (dvalid_q[i] && dframe_q[i] == in_q.frame_no) begin
				drop_hit = 1'b1;
			end
			if (!dvalid_q[i]) begin
				free_found = 1'b1;
				free_idx   = DSW'(i);
			end
			dcount = dcount + DCW'(dvalid_q[i]);
		end
	end

	always_comb begin
		size_sum = 17'(exp_q) + 17'(hdr_q & HDR_MASK);
		ok_pre = ({1'b0, in_q.packet_bytes} == size_sum) &&
			(in_q.block_size == exp_q) &&
			(32'(in_q.data_type) < NUM_TYPES) &&
			(32'(in_q.subframe_index) < NUM_SUBS) &&
			(32'(in_q.packet_index) < NUM_PACKETS);
		slot32  = (32'(in_q.data_type) * NUM_SUBS + 32'(in_q.subframe_index))
			* NUM_PACKETS + 32'(in_q.packet_index);
		addr32  = 32'(cur_buf_q) * TOTAL + 32'(slot32[SLW-1:0]);
		sweep32 = 32'(sweep_buf_q) * TOTAL + 32'(sweep_q);
	end

	always_comb begin
		t_cond   = mapped_q[tidx_q] && ((tick_q - start_q[tidx_q]) > 32'(tmo_q));
		t_better = !tfound_q || ($signed(tag_q[tidx_q]) < $signed(tag_q[tbest_q]));
		d_better = !dfound_q || ($signed(dframe_q[didx_q]) < $signed(dframe_q[dbest_q]));
		tail_sum = (CNTW + 1)'(head_q) + (CNTW + 1)'(cnt_q);
		tail_idx = (tail_sum >= (CNTW + 1)'(NUM_BUFFERS)) ?
			IDW'(tail_sum - (CNTW + 1)'(NUM_BUFFERS)) : IDW'(tail_sum);
		ret_ok   = (id32 < NUM_BUFFERS) && !mapped_q[ret_idx] && !inpool_q[ret_idx] &&
			(cnt_q < CNTW'(NUM_BUFFERS));
		rc_next  = rc_q[cur_buf_q] + CW'(1);
		miss_full = CW'(TOTAL) - rc_q[BUFW'(tbest_q)];
		bad_next = (bad_q != '1) ? bad_q + 32'd1 : bad_q;
	end

	always_comb begin
		state_d     = state_q;
		mem_rd_en   = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = addr_q;
		mem_wr_data = 1'b1;
		out_load    = 1'b0;
		out_next    = '0;
		out_next.bad_packet_count = bad_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (in_data.opcode)
						OP_PACKET: state_d = ST_LOOK;
						OP_TICK:   state_d = ST_TSCAN;
						OP_RETURN: state_d = ST_RET;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOOK: begin
				if (!new_frame || map_hit || drop_hit) begin
					state_d = ST_CHECK;
				end else if (cnt_q == '0 && !free_found) begin
					state_d = ST_DSCAN;
				end else begin
					state_d = ST_SWEEP;
				end
			end
			ST_DSCAN: begin
				if (didx_q == DSW'(DROP_SLOTS - 1)) begin
					state_d = ST_DACT;
				end
			end
			ST_DACT: begin
				state_d = dtrim_q ? ST_TRIM : ST_SWEEP;
			end
			ST_SWEEP: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = sweep32[AW-1:0];
				mem_wr_data = 1'b0;
				if (sweep_q == SLW'(TOTAL - 1)) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				mem_rd_en = ok_pre;
				state_d   = ST_RESOLVE;
			end
			ST_RESOLVE: begin
				if (out_free) begin
					out_load = 1'b1;
					out_next.frame_out = in_q.frame_no;
					out_next.last      = 1'b1;
					if (!ok_q || seen_bit) begin
						out_next.event_kind       = EV_REJECT;
						out_next.buf_idx          = buf32[2:0];
						out_next.bad_packet_count = bad_next;
					end else begin
						mem_wr_en = 1'b1;
						out_next.payload_slot = slot_q;
						if (!cur_real) begin
							out_next.event_kind = EV_DISCARD;
						end else begin
							out_next.buf_idx    = buf32[2:0];
							out_next.event_kind = (rc_next == CW'(TOTAL)) ? EV_DONE : EV_ACCEPT;
						end
					end
					state_d = ST_IDLE;
				end
			end
			ST_TSCAN: begin
				if (tidx_q == IDW'(NUM_BUFFERS - 1)) begin
					state_d = ST_TEVAL;
				end
			end
			ST_TEVAL: begin
				if (!tfound_q) begin
					state_d = ST_TRIM;
				end else if (out_free) begin
					out_load = 1'b1;
					out_next.event_kind    = EV_TIMEOUT;
					out_next.buf_idx       = 3'(32'(tbest_q));
					out_next.frame_out     = tag_q[tbest_q];
					out_next.missing_count = (miss_full > CW'(MISS_MAX)) ?
						MISS_MAX : 10'(miss_full);
					state_d = ST_TSCAN;
				end
			end
			ST_TRIM: begin
				state_d = (dcount > DCW'(DROP_KEEP)) ? ST_DSCAN : ST_TDONE;
			end
			ST_TDONE: begin
				if (out_free) begin
					out_load = 1'b1;
					out_next.event_kind = EV_TICK;
					out_next.last       = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_RET: begin
				if (out_free) begin
					out_load = 1'b1;
					out_next.event_kind = EV_RETURN;
					out_next.buf_idx    = in_q.returned_buffer;
					out_next.last       = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q       <= 16'd4928;
			hdr_q       <= 8'd64;
			tmo_q       <= 16'd1000;
			cur_valid_q <= 1'b0;
			cur_frame_q <= '0;
			cur_buf_q   <= '0;
			head_q      <= '0;
			cnt_q       <= CNTW'(NUM_BUFFERS);
			tick_q      <= '0;
			bad_q       <= '0;
			out_valid_q <= 1'b0;
			didx_q      <= '0;
			dbest_q     <= '0;
			dfound_q    <= 1'b0;
			dtrim_q     <= 1'b0;
			tidx_q      <= '0;
			tbest_q     <= '0;
			tfound_q    <= 1'b0;
			sweep_q     <= '0;
			for (int b = 0; b < NUM_BUFFERS; b++) begin
				mapped_q[b] <= 1'b0;
				inpool_q[b] <= 1'b1;
				pool_q[b]   <= IDW'(b);
			end
			for (int i = 0; i < DROP_SLOTS; i++) begin
				dvalid_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_PAYLOAD: exp_q <= cfg_data;
					REG_HEADER:  hdr_q <= cfg_data[7:0];
					REG_TIMEOUT: tmo_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_data.opcode == OP_TICK) begin
						tick_q   <= tick_q + 32'd1;
						tidx_q   <= '0;
						tfound_q <= 1'b0;
					end
				end
				ST_LOOK: begin
					sweep_q <= '0;
					if (new_frame) begin
						cur_valid_q <= 1'b1;
						cur_frame_q <= in_q.frame_no;
						if (map_hit) begin
							cur_buf_q <= BUFW'(map_idx);
						end else if (drop_hit) begin
							cur_buf_q <= DUMMY;
						end else if (cnt_q == '0) begin
							cur_buf_q <= DUMMY;
							if (free_found) begin
								dvalid_q[free_idx] <= 1'b1;
							end else begin
								didx_q   <= '0;
								dfound_q <= 1'b0;
								dtrim_q  <= 1'b0;
							end
						end else begin
							cur_buf_q          <= BUFW'(alloc_id);
							mapped_q[alloc_id] <= 1'b1;
							inpool_q[alloc_id] <= 1'b0;
							head_q <= (head_q == IDW'(NUM_BUFFERS - 1)) ? '0 : head_q + IDW'(1);
							cnt_q  <= cnt_q - CNTW'(1);
						end
					end
				end
				ST_DSCAN: begin
					if (dvalid_q[didx_q] && d_better) begin
						dfound_q <= 1'b1;
						dbest_q  <= didx_q;
					end
					didx_q <= (didx_q == DSW'(DROP_SLOTS - 1)) ? '0 : didx_q + DSW'(1);
				end
				ST_DACT: begin
					dvalid_q[dbest_q] <= !dtrim_q;
				end
				ST_SWEEP: begin
					sweep_q <= sweep_q + SLW'(1);
				end
				ST_RESOLVE: begin
					if (out_free) begin
						if (!ok_q || seen_bit) begin
							bad_q <= bad_next;
						end else if (cur_real && rc_next == CW'(TOTAL)) begin
							mapped_q[cur_idx] <= 1'b0;
							cur_valid_q       <= 1'b0;
						end
					end
				end
				ST_TSCAN: begin
					if (t_cond && t_better) begin
						tfound_q <= 1'b1;
						tbest_q  <= tidx_q;
					end
					tidx_q <= (tidx_q == IDW'(NUM_BUFFERS - 1)) ? '0 : tidx_q + IDW'(1);
				end
				ST_TEVAL: begin
					if (tfound_q && out_free) begin
						mapped_q[tbest_q] <= 1'b0;
						cur_valid_q       <= 1'b0;
						tfound_q          <= 1'b0;
						tidx_q            <= '0;
					end
				end
				ST_TRIM: begin
					didx_q   <= '0;
					dfound_q <= 1'b0;
					dtrim_q  <= 1'b1;
				end
				ST_RET: begin
					if (out_free && ret_ok) begin
						pool_q[tail_idx]  <= ret_idx;
						inpool_q[ret_idx] <= 1'b1;
						cnt_q             <= cnt_q + CNTW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_q <= in_data;
		end
		if (out_load) begin
			out_q <= out_next;
		end
		case (state_q)
			ST_LOOK: begin
				if (new_frame && !map_hit && !drop_hit) begin
					if (cnt_q == '0) begin
						rc_q[DUMMY] <= '0;
						sweep_buf_q <= DUMMY;
						if (free_found) begin
							dframe_q[free_idx] <= in_q.frame_no;
						end
					end else begin
						tag_q[alloc_id]         <= in_q.frame_no;
						start_q[alloc_id]       <= tick_q;
						rc_q[BUFW'(alloc_id)]   <= '0;
						sweep_buf_q             <= BUFW'(alloc_id);
					end
				end
			end
			ST_DACT: begin
				if (!dtrim_q) begin
					dframe_q[dbest_q] <= in_q.frame_no;
				end
			end
			ST_CHECK: begin
				ok_q   <= ok_pre;
				addr_q <= addr32[AW-1:0];
				slot_q <= slot32[8:0];
			end
			ST_RESOLVE: begin
				if (out_free && ok_q && !seen_bit && cur_real) begin
					rc_q[cur_buf_q] <= rc_next;
				end
			end
			default: ;
		endcase
	end

	ufrt_seen_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_seen (
		.clk    (clk),
		.rd_en  (mem_rd_en),
		.rd_addr(addr32[AW-1:0]),
		.rd_data(seen_bit),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

@@ hw/rtl/ufrt_seen_mem.sv @@
// Seen-bit store: one bit per packet slot per buffer, registered read.
module ufrt_seen_mem #(
	parameter int DEPTH = 4608,
	parameter int AW    = 13
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic          rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic          wr_data
);
	logic mem [DEPTH];
	logic rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
endmodule

@@ hw/rtl/ufrt_checker.sv @@
// Port-level checks for the frame reassembly tracker, bound to the top level.
module ufrt_checker
	import ufrt_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);
	// a held result must not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a real item blocks the input until its work is done
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.opcode != OP_NONE |=> in_stall)
		else $error("input taken while busy");

	a_tick_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_kind == EV_TICK |->
			out_data.last && out_data.frame_out == 32'd0)
		else $error("tick result malformed");

	a_timeout_notlast: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_kind == EV_TIMEOUT |-> !out_data.last)
		else $error("timeout result marked last");

	a_missing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_kind != EV_TIMEOUT |-> out_data.missing_count == 10'd0)
		else $error("missing count outside timeout");
endmodule

bind udp_frame_reassembly_tracker_unit ufrt_checker u_ufrt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);

@@ tb/udp_frame_reassembly_tracker_unit_tb.sv @@
// Self-checking testbench for the frame reassembly tracker: directed and random items.
`timescale 1ns / 100ps

module udp_frame_reassembly_tracker_unit_tb;
	import ufrt_pkg::*;

	localparam int N_TYPES = 2;
	localparam int N_SUBS  = 2;
	localparam int N_PKTS  = 128;
	localparam int N_BUFS  = 8;
	localparam int N_DROP  = 4;
	localparam int N_SLOTS = N_TYPES * N_SUBS * N_PKTS;
	localparam int DUMMY   = N_BUFS;
	localparam int CYCLE_LIMIT = 1000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	udp_frame_reassembly_tracker_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	in_item_t  pending[$];
	out_item_t want_results[$];
	int        fails = 0;
	int        results_seen = 0;
	bit        in_fire = 0;

	// tracker copy: registers and state
	logic [15:0] t_payload, t_timeout;
	logic [7:0]  t_header;
	bit          cur_ok;
	logic [31:0] cur_frame;
	int          cur_buf;
	logic [31:0] tag[N_BUFS];
	bit          mapped[N_BUFS];
	logic [31:0] t_start[N_BUFS];
	int          rx_cnt[N_BUFS + 1];
	bit          seen[N_BUFS + 1][N_SLOTS];
	int          pool[N_BUFS];
	int          pool_head, pool_cnt;
	bit          drop_ok[N_DROP];
	logic [31:0] drop_fr[N_DROP];
	logic [31:0] ticks, bad_cnt;

	// stimulus-side copy of the size registers
	logic [15:0] s_payload = 16'd4928;
	logic [7:0]  s_header = 8'd64;
	logic [31:0] frame_set[14];

	initial begin
		t_payload = 16'd4928;
		t_header = 8'd64;
		t_timeout = 16'd1000;
		cur_ok = 0;
		cur_frame = '0;
		cur_buf = 0;
		for (int i = 0; i < N_BUFS; i++) begin
			mapped[i] = 0;
			pool[i] = i;
		end
		pool_head = 0;
		pool_cnt = N_BUFS;
		for (int i = 0; i < N_DROP; i++) drop_ok[i] = 0;
		ticks = '0;
		bad_cnt = '0;
	end

	function automatic void add_result(logic [2:0] kind, int buf_id, logic [31:0] fr,
			int slot, int miss, bit fin);
		out_item_t r;
		r.event_kind = kind;
		r.buf_idx = buf_id[2:0];
		r.frame_out = fr;
		r.payload_slot = slot[8:0];
		r.missing_count = miss[9:0];
		r.bad_packet_count = bad_cnt;
		r.last = fin;
		want_results.push_back(r);
	endfunction

	function automatic int find_mapped(logic [31:0] fr);
		for (int b = 0; b < N_BUFS; b++)
			if (mapped[b] && tag[b] == fr) return b;
		return -1;
	endfunction

	function automatic bit in_drop(logic [31:0] fr);
		for (int i = 0; i < N_DROP; i++)
			if (drop_ok[i] && drop_fr[i] == fr) return 1;
		return 0;
	endfunction

	function automatic int smallest_drop();
		int s;
		s = -1;
		for (int i = 0; i < N_DROP; i++)
			if (drop_ok[i] && (s < 0 || $signed(drop_fr[i]) < $signed(drop_fr[s]))) s = i;
		return s;
	endfunction

	function automatic void clear_slots(int b);
		for (int j = 0; j < N_SLOTS; j++) seen[b][j] = 0;
		rx_cnt[b] = 0;
	endfunction

	function automatic void track_packet(in_item_t it);
		logic [31:0] fr;
		int b, m, s, slot, bufout;
		bit good;
		fr = it.frame_no;
		slot = 0;
		if (!cur_ok || fr != cur_frame) begin
			cur_ok = 1;
			cur_frame = fr;
			if (find_mapped(fr) < 0 && !in_drop(fr)) begin
				if (pool_cnt == 0) begin
					s = -1;
					for (int i = 0; i < N_DROP; i++)
						if (!drop_ok[i] && s < 0) s = i;
					if (s < 0) s = smallest_drop();
					drop_ok[s] = 1;
					drop_fr[s] = fr;
					clear_slots(DUMMY);
				end else begin
					b = pool[pool_head];
					pool_head = (pool_head + 1) % N_BUFS;
					pool_cnt--;
					mapped[b] = 1;
					tag[b] = fr;
					t_start[b] = ticks;
					clear_slots(b);
				end
			end
			m = find_mapped(fr);
			if (m >= 0) cur_buf = m;
			else if (in_drop(fr)) cur_buf = DUMMY;
		end
		bufout = cur_buf < N_BUFS ? cur_buf : 0;
		good = (int'(it.packet_bytes) == int'(t_payload) + int'(t_header)) &&
			it.block_size == t_payload && it.data_type < N_TYPES &&
			it.subframe_index < N_SUBS && it.packet_index < N_PKTS;
		if (good) begin
			slot = (int'(it.data_type) * N_SUBS + int'(it.subframe_index)) * N_PKTS +
				int'(it.packet_index);
			if (seen[cur_buf][slot]) good = 0;
			else seen[cur_buf][slot] = 1;
		end
		if (!good) begin
			if (bad_cnt != 32'hffff_ffff) bad_cnt++;
			add_result(EV_REJECT, bufout, fr, 0, 0, 1);
		end else if (cur_buf == DUMMY) begin
			add_result(EV_DISCARD, 0, fr, slot, 0, 1);
		end else begin
			rx_cnt[cur_buf]++;
			if (rx_cnt[cur_buf] == N_SLOTS) begin
				mapped[cur_buf] = 0;
				cur_ok = 0;
				add_result(EV_DONE, bufout, fr, slot, 0, 1);
			end else begin
				add_result(EV_ACCEPT, bufout, fr, slot, 0, 1);
			end
		end
	endfunction

	function automatic void track_tick();
		int s, n, miss, cnt;
		logic [31:0] age;
		n = 0;
		ticks++;
		forever begin
			s = -1;
			for (int b = 0; b < N_BUFS; b++) begin
				age = ticks - t_start[b];
				if (mapped[b] && age > {16'd0, t_timeout} &&
						(s < 0 || $signed(tag[b]) < $signed(tag[s]))) s = b;
			end
			if (s < 0) break;
			miss = 0;
			for (int j = 0; j < N_SLOTS; j++)
				if (!seen[s][j]) miss++;
			if (miss > int'(MISS_MAX)) miss = int'(MISS_MAX);
			mapped[s] = 0;
			add_result(EV_TIMEOUT, s, tag[s], 0, miss, 0);
			n++;
		end
		if (n > 0) cur_ok = 0;
		cnt = 0;
		for (int i = 0; i < N_DROP; i++)
			if (drop_ok[i]) cnt++;
		while (cnt > DROP_KEEP) begin
			drop_ok[smallest_drop()] = 0;
			cnt--;
		end
		add_result(EV_TICK, 0, '0, 0, 0, 1);
	endfunction

	function automatic void track_return(logic [2:0] id);
		bit listed;
		listed = 0;
		for (int i = 0; i < pool_cnt; i++)
			if (pool[(pool_head + i) % N_BUFS] == int'(id)) listed = 1;
		if (!mapped[id] && !listed && pool_cnt < N_BUFS) begin
			pool[(pool_head + pool_cnt) % N_BUFS] = int'(id);
			pool_cnt++;
		end
		add_result(EV_RETURN, int'(id), '0, 0, 0, 1);
	endfunction

	function automatic void track_item(in_item_t it);
		case (it.opcode)
			OP_PACKET: track_packet(it);
			OP_TICK:   track_tick();
			OP_RETURN: track_return(it.returned_buffer);
			default: ;
		endcase
	endfunction

	function automatic void cmp(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$error("%s: expected %0h, got %0h", name, e, a);
			fails++;
		end
	endfunction

	// input acceptance, register writes and result checking
	always @(posedge clk) begin
		out_item_t w;
		in_fire = arst_n && in_valid && !in_stall;
		if (in_fire) track_item(in_data);
		if (arst_n && cfg_wr_en) begin
			case (cfg_index)
				REG_PAYLOAD: t_payload = cfg_data;
				REG_HEADER:  t_header = cfg_data[7:0];
				REG_TIMEOUT: t_timeout = cfg_data;
				default: ;
			endcase
		end
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (want_results.size() == 0) begin
				$error("unexpected result, kind %0d", out_data.event_kind);
				fails++;
			end else begin
				w = want_results.pop_front();
				cmp("event_kind", w.event_kind, out_data.event_kind);
				cmp("buf_idx", w.buf_idx, out_data.buf_idx);
				cmp("frame_out", w.frame_out, out_data.frame_out);
				cmp("payload_slot", w.payload_slot, out_data.payload_slot);
				cmp("missing_count", w.missing_count, out_data.missing_count);
				cmp("bad_packet_count", w.bad_packet_count, out_data.bad_packet_count);
				cmp("last", w.last, out_data.last);
			end
		end
	end

	// sender: bursts of items with gaps between them
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		bit nv;
		in_item_t nd;
		nv = in_valid;
		nd = in_data;
		if (arst_n) begin
			if (in_valid && in_fire) begin
				void'(pending.pop_front());
				nv = 0;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end
			end
			if (!nv) begin
				if (gap_left > 0) gap_left--;
				else if (pending.size() > 0) begin
					nv = 1;
					nd = pending[0];
				end
			end
		end else begin
			nv = 0;
			nd = '0;
		end
		in_valid <= nv;
		in_data <= nd;
	end

	// receiver: quiet stretches, random stalls, one long hold-off
	int rx_phase = 0;
	int hold_left = 0;
	bit held_once = 0;
	always @(negedge clk) begin
		bit st;
		rx_phase++;
		if (hold_left > 0) begin
			hold_left--;
			st = 1;
		end else if (!held_once && results_seen >= 30) begin
			held_once = 1;
			hold_left = 400;
			st = 1;
		end else if ((rx_phase / 64) % 2 == 0) begin
			st = 0;
		end else begin
			st = ($urandom_range(0, 2) == 0);
		end
		out_stall <= st;
	end

	function automatic in_item_t packet(logic [31:0] fr, int ty, int sf, int pk);
		in_item_t it;
		it = '0;
		it.opcode = OP_PACKET;
		it.frame_no = fr;
		it.data_type = ty[7:0];
		it.subframe_index = sf[7:0];
		it.packet_index = pk[15:0];
		it.block_size = s_payload;
		it.packet_bytes = s_payload + {8'd0, s_header};
		it.returned_buffer = 3'($urandom);
		return it;
	endfunction

	function automatic in_item_t op_item(logic [1:0] op, int id);
		in_item_t it;
		it = '0;
		it.opcode = op;
		it.returned_buffer = id[2:0];
		return it;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int r;
		r = $urandom_range(0, 99);
		if (r < 68) begin
			it = packet(frame_set[$urandom_range(0, 13)], $urandom_range(0, N_TYPES - 1),
				$urandom_range(0, N_SUBS - 1), $urandom_range(0, N_PKTS - 1));
			if ($urandom_range(0, 19) == 0) it.frame_no = $urandom;
			if ($urandom_range(0, 6) == 0) begin
				case ($urandom_range(0, 4))
					0: it.data_type = $urandom;
					1: it.subframe_index = $urandom;
					2: it.packet_index = $urandom;
					3: it.block_size = $urandom;
					default: it.packet_bytes = $urandom;
				endcase
			end
		end else if (r < 82) begin
			it = op_item(OP_TICK, $urandom);
			it.frame_no = $urandom;
		end else if (r < 98) begin
			it = op_item(OP_RETURN, $urandom_range(0, 7));
			it.packet_bytes = $urandom;
		end else begin
			it = op_item(OP_NONE, $urandom);
		end
		return it;
	endfunction

	task automatic settle();
		while (pending.size() > 0 || in_valid || want_results.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_phase(int count);
		frame_set[0] = 32'h7fff_ffff;
		frame_set[1] = 32'h8000_0000;
		for (int i = 2; i < 14; i++) frame_set[i] = $urandom_range(0, 2) ? $urandom_range(0, 40) : $urandom;
		for (int i = 0; i < count; i++) pending.push_back(random_item());
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_PAYLOAD;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: slot extremes, duplicate, every reject cause, ops
		pending.push_back(packet(32'd100, 0, 0, 0));
		pending.push_back(packet(32'd100, 0, 0, 0));
		pending.push_back(packet(32'd100, 1, 1, 127));
		pending.push_back(packet(32'd100, 2, 0, 0));
		pending.push_back(packet(32'd100, 255, 0, 0));
		pending.push_back(packet(32'd100, 0, 2, 0));
		pending.push_back(packet(32'd100, 0, 255, 5));
		pending.push_back(packet(32'd100, 0, 0, 128));
		pending.push_back(packet(32'd100, 0, 0, 65535));
		begin
			in_item_t it;
			it = packet(32'd100, 0, 0, 9);
			it.block_size = 16'hffff;
			pending.push_back(it);
			it = packet(32'd100, 0, 0, 9);
			it.packet_bytes = 16'd0;
			pending.push_back(it);
		end
		pending.push_back(packet(32'h7fff_ffff, 0, 1, 3));
		pending.push_back(packet(32'h8000_0000, 1, 0, 3));
		pending.push_back(packet(32'hffff_ffff, 1, 1, 0));
		pending.push_back(op_item(OP_TICK, 0));
		pending.push_back(op_item(OP_RETURN, 0));
		pending.push_back(op_item(OP_RETURN, 7));
		pending.push_back(op_item(OP_NONE, 5));
		// hand every buffer back: mapped and pooled ids both
		for (int i = 0; i < N_BUFS; i++) pending.push_back(op_item(OP_RETURN, i));
		settle();

		// zero sizes, immediate timeout
		write_reg(REG_PAYLOAD, 16'd0);
		write_reg(REG_HEADER, 16'd0);
		write_reg(REG_TIMEOUT, 16'd0);
		s_payload = 16'd0;
		s_header = 8'd0;
		random_phase(25);

		// largest sizes: nothing can pass the size check
		write_reg(REG_PAYLOAD, 16'hffff);
		write_reg(REG_HEADER, {8'd0, HDR_MASK});
		write_reg(REG_TIMEOUT, 16'hffff);
		s_payload = 16'hffff;
		s_header = HDR_MASK;
		random_phase(10);

		// main random run with a short timeout
		write_reg(REG_PAYLOAD, 16'd1000);
		write_reg(REG_HEADER, 16'd20);
		write_reg(REG_TIMEOUT, 16'd3);
		s_payload = 16'd1000;
		s_header = 8'd20;
		random_phase(60);

		if (fails == 0) $display("[udp_frame_reassembly_tracker_unit] OK");
		else $display("[udp_frame_reassembly_tracker_unit] ERROR");
		$finish;
	end

	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[udp_frame_reassembly_tracker_unit] ERROR");
			$finish;
		end
	end

endmodule
